FILE: sv/spq_pkg.sv
// ---------------------------------------------------------------------------
// spq_pkg: shared codes for the stable priority queue
// Operation and status codes and the control bundle sent to each cell.
// ---------------------------------------------------------------------------
package spq_pkg;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_READ   = 1'b1;

   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_READ_OK  = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_DROPPED  = 2'd3;

   typedef struct packed {
      logic insert_en;  // insert that will be stored
      logic pop_en;     // read that removes the head
   } spq_cell_ctl_type;

endpackage

FILE: sv/stable_priority_queue.sv
// ---------------------------------------------------------------------------
// stable_priority_queue: bounded priority queue, stable among equal priorities
// Sorted chain of cells; cell 0 is the head. Inserts land after all entries
// of greater or equal priority, reads remove the head.
// ---------------------------------------------------------------------------
// The response is registered in the cycle after the request transfer.
// Throughput: one item per cycle while responses are taken (rsp_ready); every
// cell compares against the new priority in parallel and shifts in the same cycle.
// Reset clears the entry count and the response valid; cell contents are
// left as they are and never read until written.
module stable_priority_queue #(
   parameter int DEPTH         = 16,
   parameter int HANDLE_BITS   = 16,
   parameter int PRIORITY_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_func,
   input  logic [PRIORITY_BITS-1:0] req_priority_req,
   input  logic [HANDLE_BITS-1:0]   req_message_handle,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_status,
   output logic [HANDLE_BITS-1:0]   rsp_out_handle,
   output logic [PRIORITY_BITS-1:0] rsp_out_priority
);

   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [CNT_BITS-1:0]      count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [1:0]               status_ff, status_in;
   logic [HANDLE_BITS-1:0]   out_handle_ff, out_handle_in;
   logic [PRIORITY_BITS-1:0] out_priority_ff, out_priority_in;

   logic                     req_xfer;
   logic                     full;
   logic                     empty;
   spq_pkg::spq_cell_ctl_type ctl;

   logic                     ge_w       [DEPTH];
   logic [PRIORITY_BITS-1:0] priority_w [DEPTH];
   logic [HANDLE_BITS-1:0]   handle_w   [DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;
   assign full      = (count_ff == CNT_BITS'(DEPTH));
   assign empty     = (count_ff == '0);

   assign ctl.insert_en = req_xfer && (req_func == spq_pkg::FUNC_INSERT) && !full;
   assign ctl.pop_en    = req_xfer && (req_func == spq_pkg::FUNC_READ) && !empty;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                     left_ge;
      logic [PRIORITY_BITS-1:0] left_priority, right_priority;
      logic [HANDLE_BITS-1:0]   left_handle, right_handle;

      if (i == 0) begin : g_head
         assign left_ge       = 1'b1;
         assign left_priority = req_priority_req;
         assign left_handle   = req_message_handle;
      end else begin : g_body
         assign left_ge       = ge_w[i-1];
         assign left_priority = priority_w[i-1];
         assign left_handle   = handle_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_priority = priority_w[i];
         assign right_handle   = handle_w[i];
      end else begin : g_inner
         assign right_priority = priority_w[i+1];
         assign right_handle   = handle_w[i+1];
      end

      spq_cell #(
         .HANDLE_BITS   (HANDLE_BITS),
         .PRIORITY_BITS (PRIORITY_BITS)
      ) u_cell (
         .clock          (clock),
         .ctl            (ctl),
         .occ            (CNT_BITS'(i) < count_ff),
         .new_priority   (req_priority_req),
         .new_handle     (req_message_handle),
         .left_ge        (left_ge),
         .left_priority  (left_priority),
         .left_handle    (left_handle),
         .right_priority (right_priority),
         .right_handle   (right_handle),
         .ge             (ge_w[i]),
         .priority_out   (priority_w[i]),
         .handle_out     (handle_w[i])
      );
   end

   always_comb begin
      count_in        = count_ff;
      rsp_valid_in    = rsp_valid_ff;
      status_in       = status_ff;
      out_handle_in   = out_handle_ff;
      out_priority_in = out_priority_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_xfer) begin
         rsp_valid_in    = 1'b1;
         out_handle_in   = '0;
         out_priority_in = '0;
         if (req_func == spq_pkg::FUNC_INSERT) begin
            if (full) begin
               status_in = spq_pkg::ST_DROPPED;
            end else begin
               status_in = spq_pkg::ST_INSERTED;
               count_in  = count_ff + CNT_BITS'(1);
            end
         end else begin
            if (empty) begin
               status_in = spq_pkg::ST_EMPTY;
            end else begin
               status_in       = spq_pkg::ST_READ_OK;
               out_handle_in   = handle_w[0];
               out_priority_in = priority_w[0];
               count_in        = count_ff - CNT_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff       <= status_in;
      out_handle_ff   <= out_handle_in;
      out_priority_ff <= out_priority_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_handle   = out_handle_ff;
   assign rsp_out_priority = out_priority_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("entry count exceeds depth");

   a_full_drop : assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_func == spq_pkg::FUNC_INSERT && full)
      |=> (rsp_status == spq_pkg::ST_DROPPED && $stable(count_ff)))
      else $error("insert into full store not dropped");

   a_empty_read : assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_func == spq_pkg::FUNC_READ && empty)
      |=> (rsp_status == spq_pkg::ST_EMPTY && count_ff == '0))
      else $error("read on empty store mishandled");

   a_zero_payload : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != spq_pkg::ST_READ_OK)
      |-> (rsp_out_handle == '0 && rsp_out_priority == '0))
      else $error("nonzero payload on non-read response");

endmodule

FILE: sv/spq_cell.sv
// ---------------------------------------------------------------------------
// spq_cell: one slot of the sorted store
// Holds one entry. On insert it keeps its entry, loads the new entry or
// takes its left neighbor's entry; on pop it takes its right neighbor's.
// ---------------------------------------------------------------------------
module spq_cell #(
   parameter int HANDLE_BITS   = 16,
   parameter int PRIORITY_BITS = 8
) (
   input  logic                      clock,
   input  spq_pkg::spq_cell_ctl_type ctl,
   input  logic                      occ,
   input  logic [PRIORITY_BITS-1:0]  new_priority,
   input  logic [HANDLE_BITS-1:0]    new_handle,
   input  logic                      left_ge,
   input  logic [PRIORITY_BITS-1:0]  left_priority,
   input  logic [HANDLE_BITS-1:0]    left_handle,
   input  logic [PRIORITY_BITS-1:0]  right_priority,
   input  logic [HANDLE_BITS-1:0]    right_handle,
   output logic                      ge,
   output logic [PRIORITY_BITS-1:0]  priority_out,
   output logic [HANDLE_BITS-1:0]    handle_out
);

   logic [PRIORITY_BITS-1:0] priority_ff, priority_in;
   logic [HANDLE_BITS-1:0]   handle_ff, handle_in;

   // entry stays in front of the new one when its priority is not lower
   assign ge = occ && (priority_ff >= new_priority);

   always_comb begin
      priority_in = priority_ff;
      handle_in   = handle_ff;
      if (ctl.insert_en) begin
         if (!ge) begin
            if (left_ge) begin
               priority_in = new_priority;
               handle_in   = new_handle;
            end else begin
               priority_in = left_priority;
               handle_in   = left_handle;
            end
         end
      end else if (ctl.pop_en) begin
         priority_in = right_priority;
         handle_in   = right_handle;
      end
   end

   always_ff @(posedge clock) begin
      priority_ff <= priority_in;
      handle_ff   <= handle_in;
   end

   assign priority_out = priority_ff;
   assign handle_out   = handle_ff;

endmodule
